/* rtl/core/opd_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// opd_pkg: shared types and constants for the Ogg page deframer
// Capture pattern, header offsets, result codes and the per-byte CRC step.
// ---------------------------------------------------------------------------
package opd_pkg;

  localparam int MAX_SEGMENTS_DEF = 255;

  localparam logic [31:0] CAPTURE   = 32'h4F676753;
  localparam logic [31:0] CRC_POLY  = 32'h04C11DB7;
  localparam logic [4:0]  SYNC_SIZE = 5'd4;
  localparam logic [4:0]  FLAGS_POS = 5'd5;
  localparam logic [4:0]  GRAN_POS  = 5'd6;
  localparam logic [4:0]  SER_POS   = 5'd14;
  localparam logic [4:0]  PAGE_POS  = 5'd18;
  localparam logic [4:0]  CKSUM_POS = 5'd22;
  localparam logic [4:0]  HDR_LAST  = 5'd26;

  localparam logic [2:0] KIND_HDR  = 3'd0;
  localparam logic [2:0] KIND_DATA = 3'd1;
  localparam logic [2:0] KIND_END  = 3'd2;
  localparam logic [2:0] KIND_SYNC = 3'd3;
  localparam logic [2:0] KIND_VER  = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic        segment_end;
    logic        continued_packet;
    logic        first_page;
    logic        last_page;
    logic [63:0] granule_position;
    logic [31:0] stream_serial;
    logic [31:0] page_number;
    logic [7:0]  segment_count;
    logic        crc_ok;
  } result_t;

  // One queued request: its first result, and a page end that may trail it.
  typedef struct packed {
    result_t res;
    logic    end_follows;
    logic    end_crc_ok;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  localparam logic [31:0] CRC_OGGS =
    crc_byte(crc_byte(crc_byte(crc_byte(32'd0, 8'h4F), 8'h67), 8'h67), 8'h53);

endpackage

/* rtl/core/opd_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// opd_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module opd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 255,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/ogg_page_deframer.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ogg_page_deframer: Ogg page parser with CRC-32 check
// Hunts for the capture pattern, parses the page header, stores the lacing
// table and passes payload bytes through with segment-end marks.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/data_byte) takes one raw stream byte
//   per request. Output channel (out_valid/out_ready/...) delivers result
//   requests: header info, payload byte, page end (with crc_ok), sync lost
//   or bad version. Fields that do not belong to a result's kind read 0.
//   Configuration channel (cfg_valid/cfg_ready/max_resync) is always ready;
//   write it only while the block is idle.
// Timing and throughput:
//   A result is registered in the result queue before it reaches the output.
//   One byte per cycle is sustained while the receiver keeps up; a byte that
//   causes two results (payload byte or header plus page end) delivers them
//   as two output requests from one queue entry. The lacing table lives in
//   a RAM with registered read, and only nonzero lacing values are stored,
//   packed, so the next segment length is always prefetched one entry ahead.
// Reset:
//   Synchronous, active high. The block starts hunting with an empty window,
//   the result queue empty and max_resync at 65535. The lacing RAM needs no
//   clearing: an entry is read only after this page wrote it.
// Stalls:
//   A two-entry result queue parts the sides; in_ready drops only when both
//   entries hold undelivered results. Results are never lost or repeated.
// ---------------------------------------------------------------------------
module ogg_page_deframer
  import opd_pkg::*;
#(
  parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic        segment_end,
  output logic        continued_packet,
  output logic        first_page,
  output logic        last_page,
  output logic [63:0] granule_position,
  output logic [31:0] stream_serial,
  output logic [31:0] page_number,
  output logic [7:0]  segment_count,
  output logic        crc_ok,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] max_resync
);

  localparam int AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [8:0] MAX_SEG9 = 9'(MAX_SEGMENTS);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_LACE = 2'd2;
  localparam logic [1:0] PH_PAY  = 2'd3;

  // Parser state
  logic [1:0]    phase, phase_next;
  logic [31:0]   sync_window, sync_window_next;
  logic [4:0]    header_index, header_index_next;
  logic [15:0]   resync_count, resync_count_next;
  logic [15:0]   resync_limit;
  logic [2:0]    header_flags, header_flags_next;
  logic [63:0]   granule_reg, granule_reg_next;
  logic [31:0]   serial_reg, serial_reg_next;
  logic [31:0]   page_no_reg, page_no_reg_next;
  logic [31:0]   stored_crc, stored_crc_next;
  logic [31:0]   running_crc, running_crc_next;
  logic [7:0]    nsegs, nsegs_next;
  logic [7:0]    seg_index, seg_index_next;
  logic [7:0]    seg_remaining, seg_remaining_next;
  logic [7:0]    first_len, first_len_next;
  logic [CW-1:0] nz_count, nz_count_next;
  logic [CW-1:0] rd_ptr, rd_ptr_next;

  // Lacing RAM and write-to-read bypass
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_rdata;
  logic          bypass;
  logic [7:0]    bypass_data;
  logic [7:0]    next_len;

  // Result queue
  entry_t        queue [2];
  logic          wr_sel, rd_sel, second;
  logic [1:0]    q_count;
  logic          push, pop, in_acc, out_acc;
  entry_t        new_entry;
  logic [31:0]   crc_step;
  logic [7:0]    crc_in;
  entry_t        head;

  assign in_ready  = (q_count < 2'd2);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign next_len  = bypass ? bypass_data : ram_rdata;
  assign ram_waddr = nz_count[AW-1:0];

  opd_ram #(
    .WIDTH(8),
    .DEPTH(MAX_SEGMENTS)
  ) u_lacing (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(data_byte),
    .raddr(rd_ptr_next[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign crc_in   = (phase == PH_HDR && header_index >= CKSUM_POS && header_index < HDR_LAST)
                    ? 8'd0 : data_byte;
  assign crc_step = crc_byte(running_crc, crc_in);

  always_comb begin
    phase_next         = phase;
    sync_window_next   = sync_window;
    header_index_next  = header_index;
    resync_count_next  = resync_count;
    header_flags_next  = header_flags;
    granule_reg_next   = granule_reg;
    serial_reg_next    = serial_reg;
    page_no_reg_next   = page_no_reg;
    stored_crc_next    = stored_crc;
    running_crc_next   = running_crc;
    nsegs_next         = nsegs;
    seg_index_next     = seg_index;
    seg_remaining_next = seg_remaining;
    first_len_next     = first_len;
    nz_count_next      = nz_count;
    rd_ptr_next        = rd_ptr;
    ram_we             = 1'b0;
    push               = 1'b0;
    new_entry          = '0;

    if (in_acc) begin
      unique case (phase)
        PH_HDR: begin
          running_crc_next = crc_step;
          if (header_index < HDR_LAST) begin
            header_index_next = header_index + 5'd1;
          end
          if (header_index == SYNC_SIZE) begin
            if (data_byte != 8'd0) begin
              push               = 1'b1;
              new_entry.res.kind = KIND_VER;
              phase_next         = PH_HUNT;
              sync_window_next   = '0;
              header_index_next  = '0;
              resync_count_next  = '0;
            end
          end else if (header_index == FLAGS_POS) begin
            header_flags_next = data_byte[2:0];
          end else if (header_index >= GRAN_POS && header_index < SER_POS) begin
            granule_reg_next = {data_byte, granule_reg[63:8]};
          end else if (header_index >= SER_POS && header_index < PAGE_POS) begin
            serial_reg_next = {data_byte, serial_reg[31:8]};
          end else if (header_index >= PAGE_POS && header_index < CKSUM_POS) begin
            page_no_reg_next = {data_byte, page_no_reg[31:8]};
          end else if (header_index >= CKSUM_POS && header_index < HDR_LAST) begin
            stored_crc_next = {data_byte, stored_crc[31:8]};
          end else if (header_index == HDR_LAST) begin
            nsegs_next                         = data_byte;
            push                               = 1'b1;
            new_entry.res.kind                 = KIND_HDR;
            new_entry.res.continued_packet     = header_flags[0];
            new_entry.res.first_page           = header_flags[1];
            new_entry.res.last_page            = header_flags[2];
            new_entry.res.granule_position     = granule_reg;
            new_entry.res.stream_serial        = serial_reg;
            new_entry.res.page_number          = page_no_reg;
            new_entry.res.segment_count        = data_byte;
            seg_index_next                     = '0;
            nz_count_next                      = '0;
            if (data_byte == 8'd0) begin
              // Empty page: page end rides with the header info.
              new_entry.end_follows = 1'b1;
              new_entry.end_crc_ok  = (crc_step == stored_crc);
              phase_next            = PH_HUNT;
              sync_window_next      = '0;
              header_index_next     = '0;
              resync_count_next     = '0;
            end else begin
              phase_next = PH_LACE;
            end
          end
        end

        PH_LACE: begin
          running_crc_next = crc_step;
          seg_index_next   = seg_index + 8'd1;
          // Store nonzero lacing values only, packed from entry 0.
          if ({1'b0, seg_index} < MAX_SEG9 && data_byte != 8'd0) begin
            ram_we        = 1'b1;
            nz_count_next = nz_count + CW'(1);
            if (nz_count == '0) begin
              first_len_next = data_byte;
            end
          end
          rd_ptr_next = CW'(1);
          if (({1'b0, seg_index} + 9'd1) >= {1'b0, nsegs}) begin
            if (nz_count_next != '0) begin
              phase_next         = PH_PAY;
              seg_remaining_next = first_len_next;
            end else begin
              push                 = 1'b1;
              new_entry.res.kind   = KIND_END;
              new_entry.res.crc_ok = (crc_step == stored_crc);
              phase_next           = PH_HUNT;
              sync_window_next     = '0;
              header_index_next    = '0;
              resync_count_next    = '0;
            end
          end
        end

        PH_PAY: begin
          running_crc_next          = crc_step;
          push                      = 1'b1;
          new_entry.res.kind        = KIND_DATA;
          new_entry.res.payload_byte = data_byte;
          new_entry.res.segment_end = (seg_remaining <= 8'd1);
          if (seg_remaining <= 8'd1) begin
            if (rd_ptr == nz_count) begin
              new_entry.end_follows = 1'b1;
              new_entry.end_crc_ok  = (crc_step == stored_crc);
              phase_next            = PH_HUNT;
              sync_window_next      = '0;
              header_index_next     = '0;
              resync_count_next     = '0;
            end else begin
              seg_remaining_next = next_len;
              rd_ptr_next        = rd_ptr + CW'(1);
            end
          end else begin
            seg_remaining_next = seg_remaining - 8'd1;
          end
        end

        PH_HUNT: begin
          sync_window_next = {sync_window[23:0], data_byte};
          if (header_index < SYNC_SIZE) begin
            header_index_next = header_index + 5'd1;
          end
          if (header_index_next >= SYNC_SIZE && sync_window_next == CAPTURE) begin
            phase_next        = PH_HDR;
            header_index_next = SYNC_SIZE;
            resync_count_next = '0;
            header_flags_next = '0;
            running_crc_next  = CRC_OGGS;
          end else if (header_index_next >= SYNC_SIZE) begin
            if (resync_count >= resync_limit) begin
              push               = 1'b1;
              new_entry.res.kind = KIND_SYNC;
              sync_window_next   = '0;
              header_index_next  = '0;
              resync_count_next  = '0;
            end else begin
              resync_count_next = resync_count + 16'd1;
            end
          end
        end

        default: begin
          phase_next = PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      sync_window   <= '0;
      header_index  <= '0;
      resync_count  <= '0;
      resync_limit  <= 16'hFFFF;
      seg_index     <= '0;
      seg_remaining <= '0;
      nz_count      <= '0;
      rd_ptr        <= '0;
      bypass        <= 1'b0;
    end else begin
      phase         <= phase_next;
      sync_window   <= sync_window_next;
      header_index  <= header_index_next;
      resync_count  <= resync_count_next;
      seg_index     <= seg_index_next;
      seg_remaining <= seg_remaining_next;
      nz_count      <= nz_count_next;
      rd_ptr        <= rd_ptr_next;
      // Forward a lacing value written at the address being read.
      bypass        <= ram_we && (ram_waddr == rd_ptr_next[AW-1:0]);
      if (cfg_valid && cfg_ready) begin
        resync_limit <= max_resync;
      end
    end
  end

  always_ff @(posedge clk) begin
    header_flags <= header_flags_next;
    granule_reg  <= granule_reg_next;
    serial_reg   <= serial_reg_next;
    page_no_reg  <= page_no_reg_next;
    stored_crc   <= stored_crc_next;
    running_crc  <= running_crc_next;
    nsegs        <= nsegs_next;
    first_len    <= first_len_next;
    bypass_data  <= data_byte;
  end

  // Result queue: two requests deep, each may carry a trailing page end.
  assign head      = queue[rd_sel];
  assign out_valid = (q_count != 2'd0);
  assign out_acc   = out_valid && out_ready;
  assign pop       = out_acc && (!head.end_follows || second);

  always_comb begin
    kind             = head.res.kind;
    payload_byte     = head.res.payload_byte;
    segment_end      = head.res.segment_end;
    continued_packet = head.res.continued_packet;
    first_page       = head.res.first_page;
    last_page        = head.res.last_page;
    granule_position = head.res.granule_position;
    stream_serial    = head.res.stream_serial;
    page_number      = head.res.page_number;
    segment_count    = head.res.segment_count;
    crc_ok           = head.res.crc_ok;
    if (second) begin
      kind             = KIND_END;
      payload_byte     = '0;
      segment_end      = 1'b0;
      continued_packet = 1'b0;
      first_page       = 1'b0;
      last_page        = 1'b0;
      granule_position = '0;
      stream_serial    = '0;
      page_number      = '0;
      segment_count    = '0;
      crc_ok           = head.end_crc_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel  <= 1'b0;
      rd_sel  <= 1'b0;
      q_count <= '0;
      second  <= 1'b0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
        second <= 1'b0;
      end else if (out_acc) begin
        second <= 1'b1;
      end
      q_count <= q_count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_sel] <= new_entry;
    end
  end

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (rst) q_count <= 2'd2)
    else $error("result queue overflow");
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> seg_remaining != 8'd0)
    else $error("payload phase with empty segment");
  a_nz_bound: assert property (@(posedge clk) disable iff (rst)
    nz_count <= CW'(MAX_SEGMENTS))
    else $error("lacing store overrun");
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> rd_ptr <= nz_count)
    else $error("segment pointer past stored entries");

endmodule

/* verif/opd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// opd_checker: result predictor and scoreboard for the Ogg page deframer
// Watches the byte, result and configuration channels, models the page
// parser per accepted byte and compares every result field by field.
// ---------------------------------------------------------------------------
module opd_checker
  import opd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  result_t     got,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] max_resync,
  output int          fail_count,
  output int          pending
);

  typedef enum logic [1:0] {PH_HUNT, PH_HDR, PH_LACE, PH_DATA} phase_e;

  localparam int NSEG = 255;

  logic [15:0] resync_limit;
  logic [31:0] window;
  logic [15:0] miss_count;
  phase_e      ph;
  logic [4:0]  hidx;
  logic [2:0]  flags;
  logic [63:0] granule;
  logic [31:0] serial, page_no, crc_stored, crc_run;
  logic [7:0]  nsegs, seg_idx, seg_left;
  logic [7:0]  lacing [NSEG];
  result_t     expected_results[$];

  assign pending = expected_results.size();

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    c = c ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    return c;
  endfunction

  function automatic result_t blank(input logic [2:0] k);
    result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  task automatic go_hunt();
    ph = PH_HUNT;
    window = '0;
    hidx = '0;
    miss_count = '0;
  endtask

  task automatic push_page_end();
    result_t r;
    r = blank(KIND_END);
    r.crc_ok = (crc_run == crc_stored);
    expected_results.push_back(r);
    go_hunt();
  endtask

  // Find the next nonempty stored segment at or after 'from'.
  function automatic bit find_segment(input int from);
    int lim;
    lim = (nsegs < NSEG) ? nsegs : NSEG;
    for (int i = from; i < lim; i++) begin
      if (lacing[i] != 0) begin
        seg_idx = 8'(i);
        seg_left = lacing[i];
        return 1;
      end
    end
    seg_idx = lim[7:0];
    seg_left = 0;
    return 0;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    int idx;
    idx = hidx;
    case (ph)
      PH_HDR: begin
        crc_run = crc_step(crc_run, (idx >= 22 && idx < 26) ? 8'd0 : b);
        if (idx == 4) begin
          if (b != 0) begin
            expected_results.push_back(blank(KIND_VER));
            go_hunt();
            return;
          end
        end else if (idx == 5) flags = b[2:0];
        else if (idx >= 6 && idx <= 13) granule |= 64'(b) << (8 * (idx - 6));
        else if (idx >= 14 && idx <= 17) serial |= 32'(b) << (8 * (idx - 14));
        else if (idx >= 18 && idx <= 21) page_no |= 32'(b) << (8 * (idx - 18));
        else if (idx >= 22 && idx <= 25) crc_stored |= 32'(b) << (8 * (idx - 22));
        else if (idx == 26) begin
          nsegs = b;
          r = blank(KIND_HDR);
          r.continued_packet = flags[0];
          r.first_page = flags[1];
          r.last_page = flags[2];
          r.granule_position = granule;
          r.stream_serial = serial;
          r.page_number = page_no;
          r.segment_count = nsegs;
          expected_results.push_back(r);
          if (nsegs == 0) push_page_end();
          else begin
            ph = PH_LACE;
            seg_idx = 0;
          end
          return;
        end
        hidx = (idx == 26) ? 5'd26 : 5'(idx + 1);
      end
      PH_LACE: begin
        crc_run = crc_step(crc_run, b);
        if (seg_idx < NSEG) lacing[seg_idx] = b;
        seg_idx++;
        if (seg_idx >= nsegs) begin
          if (find_segment(0)) ph = PH_DATA;
          else push_page_end();
        end
      end
      PH_DATA: begin
        crc_run = crc_step(crc_run, b);
        r = blank(KIND_DATA);
        r.payload_byte = b;
        r.segment_end = (seg_left <= 1);
        expected_results.push_back(r);
        if (seg_left > 0) seg_left--;
        if (seg_left == 0 && !find_segment(seg_idx + 1)) push_page_end();
      end
      default: begin
        window = {window[23:0], b};
        if (hidx < 4) hidx++;
        if (hidx >= 4 && window == CAPTURE) begin
          ph = PH_HDR;
          hidx = 4;
          miss_count = 0;
          flags = 0;
          granule = 0;
          serial = 0;
          page_no = 0;
          crc_stored = 0;
          nsegs = 0;
          seg_idx = 0;
          seg_left = 0;
          crc_run = crc_step(crc_step(crc_step(crc_step(32'd0, 8'h4F), 8'h67), 8'h67), 8'h53);
        end else if (hidx >= 4) begin
          if (miss_count >= resync_limit) begin
            expected_results.push_back(blank(KIND_SYNC));
            go_hunt();
          end else miss_count++;
        end
      end
    endcase
  endtask

  task automatic compare_result(input result_t r);
    result_t e;
    if (expected_results.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result kind=%0d", r.kind);
      return;
    end
    e = expected_results.pop_front();
    if (r !== e) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("exp kind=%0d byte=%h end=%b flg=%b%b%b gr=%h se=%h pg=%h n=%0d ok=%b",
                 e.kind, e.payload_byte, e.segment_end, e.last_page, e.first_page,
                 e.continued_packet, e.granule_position, e.stream_serial, e.page_number,
                 e.segment_count, e.crc_ok);
        $display("act kind=%0d byte=%h end=%b flg=%b%b%b gr=%h se=%h pg=%h n=%0d ok=%b",
                 r.kind, r.payload_byte, r.segment_end, r.last_page, r.first_page,
                 r.continued_packet, r.granule_position, r.stream_serial, r.page_number,
                 r.segment_count, r.crc_ok);
      end
    end
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    if (rst) begin
      resync_limit = 16'hFFFF;
      go_hunt();
      flags = 0;
      granule = 0;
      serial = 0;
      page_no = 0;
      crc_stored = 0;
      crc_run = 0;
      nsegs = 0;
      seg_idx = 0;
      seg_left = 0;
      expected_results.delete();
    end else begin
      // Compare before predicting: a result never shows up in the cycle of its byte.
      if (out_valid && out_ready) compare_result(got);
      if (cfg_valid && cfg_ready) resync_limit = max_resync;
      if (in_valid && in_ready) parse_byte(data_byte);
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb: stimulus and verdict for the Ogg page deframer
// Feeds directed and random Ogg pages, broken pages and noise under random
// idling on both sides; a checker beside the block predicts and compares.
// ---------------------------------------------------------------------------
module tb;
  import opd_pkg::*;

  localparam int WATCHDOG = 20000;

  logic        clk, rst;
  logic        in_valid, in_ready;
  logic [7:0]  data_byte;
  logic        out_valid, out_ready;
  result_t     got;
  logic        cfg_valid, cfg_ready;
  logic [15:0] max_resync;
  int          fail_count, pending;
  int          idle_cycles;
  int          bytes_sent;
  bit          calm;        // when set, neither side idles
  bit          timed_out;

  ogg_page_deframer dut (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .out_valid, .out_ready,
    .kind(got.kind), .payload_byte(got.payload_byte), .segment_end(got.segment_end),
    .continued_packet(got.continued_packet), .first_page(got.first_page),
    .last_page(got.last_page), .granule_position(got.granule_position),
    .stream_serial(got.stream_serial), .page_number(got.page_number),
    .segment_count(got.segment_count), .crc_ok(got.crc_ok),
    .cfg_valid, .cfg_ready, .max_resync
  );

  opd_checker chk (
    .clk, .rst, .in_valid, .in_ready, .data_byte, .out_valid, .out_ready, .got,
    .cfg_valid, .cfg_ready, .max_resync, .fail_count, .pending
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stall the receiver about one cycle in five, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 20);
  end

  // Count cycles with no request moving on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    timed_out = 0;
    wait (idle_cycles >= WATCHDOG);
    timed_out = 1;
  end

  // Send one byte; hold valid until the request is taken, maybe idle first.
  task automatic send_byte(input logic [7:0] b);
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic drop_valid();
    in_valid <= 0;
  endtask

  task automatic send_word(input logic [63:0] v, input int nbytes);
    for (int i = 0; i < nbytes; i++) send_byte(v[8 * i +: 8]);
  endtask

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    c = c ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) c = c[31] ? ((c << 1) ^ 32'h04C11DB7) : (c << 1);
    return c;
  endfunction

  // Build and send one page. Lacing values come from lace[], payload bytes
  // random. good_crc picks a correct checksum, else a random one.
  task automatic send_page(input logic [7:0] version, input logic [7:0] flag_byte,
                           input logic [63:0] granule, input logic [31:0] serial,
                           input logic [31:0] page_no, input logic [7:0] lace[$],
                           input bit good_crc);
    logic [7:0] page[$];
    logic [31:0] crc;
    int total;
    page = '{8'h4F, 8'h67, 8'h67, 8'h53, version, flag_byte};
    for (int i = 0; i < 8; i++) page.push_back(granule[8 * i +: 8]);
    for (int i = 0; i < 4; i++) page.push_back(serial[8 * i +: 8]);
    for (int i = 0; i < 4; i++) page.push_back(page_no[8 * i +: 8]);
    for (int i = 0; i < 4; i++) page.push_back(8'd0);
    page.push_back(8'(lace.size()));
    total = 0;
    foreach (lace[i]) begin
      page.push_back(lace[i]);
      total += lace[i];
    end
    for (int i = 0; i < total; i++) page.push_back(8'($urandom_range(255)));
    crc = 0;
    foreach (page[i]) crc = crc_step(crc, page[i]);
    if (!good_crc) crc = $urandom;
    for (int i = 0; i < 4; i++) page[22 + i] = crc[8 * i +: 8];
    // A bad version ends the page after the version byte.
    if (version != 0) page = page[0:4];
    foreach (page[i]) send_byte(page[i]);
  endtask

  task automatic wait_drain();
    drop_valid();
    while (pending != 0 && !timed_out) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] v);
    cfg_valid <= 1;
    max_resync <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic random_lacing(output logic [7:0] lace[$]);
    int n;
    lace = {};
    n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(5))
        0: lace.push_back(8'd0);
        1: lace.push_back(8'd255);
        default: lace.push_back(8'($urandom_range(1, 12)));
      endcase
    end
  endtask

  initial begin
    logic [7:0] lace[$];
    logic [7:0] big[$];
    int pick;
    rst = 1;
    in_valid = 0;
    data_byte = 0;
    out_ready = 0;
    cfg_valid = 0;
    max_resync = 16'hFFFF;
    calm = 0;
    bytes_sent = 0;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    fork
      begin
        // Directed: loose limit, then extremes of every header field.
        write_limit(16'hFFFF);
        lace = '{8'd3, 8'd0, 8'd1};
        send_page(8'd0, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  lace, 1);
        lace = {};   // empty page: header and page end on one byte
        send_page(8'd0, 8'h00, 64'd0, 32'd0, 32'd0, lace, 0);
        lace = '{8'd0, 8'd0};   // all segments empty
        send_page(8'd0, 8'h05, 64'h0123_4567_89AB_CDEF, 32'hA5A5_5A5A, 32'd1, lace, 1);
        lace = '{8'd1};
        send_page(8'h80, 8'h02, 64'd7, 32'd7, 32'd7, lace, 1);   // bad version
        send_byte(8'h4F); send_byte(8'h4F); send_byte(8'h67);    // overlap in window
        send_byte(8'h67); send_byte(8'h53); send_byte(8'h01);    // version 1 rejected
        wait_drain();

        // Tight limit: zero tolerance, then a small one, with noise.
        write_limit(16'd0);
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(255)));
        wait_drain();
        write_limit(16'd3);
        for (int i = 0; i < 12; i++) send_byte(8'($urandom_range(255)));
        lace = '{8'd2};
        send_page(8'd0, 8'h01, 64'd1, 32'd2, 32'd3, lace, 1);
        wait_drain();

        // One page at the table size: more than 255 lacing values are not
        // possible in one byte, so fill the table fully with short segments.
        write_limit(16'hFFFF);
        big = {};
        for (int i = 0; i < 255; i++) big.push_back((i % 50 == 0) ? 8'd1 : 8'd0);
        send_page(8'd0, 8'h00, 64'd9, 32'd9, 32'd9, big, 1);
        wait_drain();

        // Random pages, broken pages and noise across several limits.
        for (int p = 0; bytes_sent < 1900 && !timed_out; p++) begin
          if (p % 25 == 0) begin
            wait_drain();
            case ($urandom_range(3))
              0: write_limit(16'd0);
              1: write_limit(16'($urandom_range(1, 40)));
              2: write_limit(16'($urandom_range(65535)));
              default: write_limit(16'hFFFF);
            endcase
          end
          calm = (p >= 40 && p < 55);
          random_lacing(lace);
          pick = $urandom_range(99);
          if (pick < 70)
            send_page(8'd0, 8'($urandom_range(255)), {$urandom, $urandom}, $urandom,
                      $urandom, lace, $urandom_range(3) != 0);
          else if (pick < 80)
            send_page(8'($urandom_range(1, 255)), 8'($urandom_range(255)), 64'd0, 32'd0,
                      32'd0, lace, 1);
          else if (pick < 90) begin
            send_byte(8'h4F); send_byte(8'h67);   // broken capture pattern
            send_byte(8'($urandom_range(255)));
          end else
            for (int i = $urandom_range(1, 8); i > 0; i--) send_byte(8'($urandom_range(255)));
        end
        calm = 0;
        wait_drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
      end
      begin
        wait (timed_out);
        $display("TB_ERROR");
        $finish;
      end
    join
  end

endmodule

/* filelist.f */
rtl/core/opd_pkg.sv
rtl/core/opd_ram.sv
rtl/core/ogg_page_deframer.sv
verif/opd_checker.sv
verif/tb.sv
